// File: rtl/core/etts_pkg.sv
// Package for the ephemeris time table store: sizes, codes and shared types.
// No dependencies; used by every module of the store.
`default_nettype none
package etts_pkg;
  localparam int NumSats = 64;
  localparam int EntriesPerSat = 16;
  localparam int SatW = 6;
  localparam int PosW = $clog2(EntriesPerSat);
  localparam int CntW = PosW + 1;
  localparam int AddrW = SatW + PosW;
  localparam int Depth = NumSats * EntriesPerSat;

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_USER   = 2'd1,
    REQ_NEAR   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUP       = 3'd1,
    ST_CONFLICT  = 3'd2,
    ST_MATCHLAST = 3'd3,
    ST_LATE      = 3'd4,
    ST_REPLACED  = 3'd5,
    ST_FULL      = 3'd6,
    ST_LOOKUP    = 3'd7
  } status_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RDA, S_RDB, S_SHIFT, S_DONE
  } bst_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    req_t                 req;
    logic                 sat_ok;
    logic [SatW-1:0]      sat;
    logic [31:0]          key;
    logic [31:0]          rbegin;
    logic [31:0]          rend;
    logic [31:0]          rtoe;
  } cmd_t;

  typedef struct packed {
    logic [95:0] rec;
    logic [31:0] key;
  } ent_t;
endpackage
`default_nettype wire

// File: rtl/core/ephemeris_time_table_store_core.sv
// Top level of the ephemeris time table store: front queue plus table back end.
// Depends on etts_pkg, etts_front and etts_back.
`default_nettype none
// Per-satellite sorted record store (64 satellites x 16 records). Each request
// is queued by the front and run by the back, which scans the table one memory
// read per cycle; an insert that adds a record then moves each later entry up
// with a read and a write, and writes the new record last. The record memory
// has one write port and one registered read port.
// Results come one per request, in order; the user must write cfg_key_by_begin
// only when idle, which the block itself does not enforce.
module ephemeris_time_table_store_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire         cfg_key_by_begin,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_req_type,
  input  wire  [5:0]  in_sat_index,
  input  wire  [31:0] in_rec_begin,
  input  wire  [31:0] in_rec_end,
  input  wire  [31:0] in_rec_toe,
  input  wire  [31:0] in_query_time,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_status,
  output logic        out_found,
  output logic [31:0] out_begin,
  output logic [31:0] out_end,
  output logic [31:0] out_toe
);
  logic kbb_r;
  logic cmd_valid, cmd_take;
  etts_pkg::cmd_t cmd;

  // Hold the key mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbb_r <= 1'b0;
    end else if (cfg_we) begin
      kbb_r <= cfg_key_by_begin;
    end
  end

  etts_front u_front (
    .clk, .rst_n, .cfg_key_by_begin(kbb_r), .in_valid, .in_stall,
    .in_req_type, .in_sat_index, .in_rec_begin, .in_rec_end, .in_rec_toe,
    .in_query_time, .cmd_valid, .cmd, .cmd_take
  );

  etts_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .out_valid, .out_stall,
    .out_status, .out_found, .out_begin, .out_end, .out_toe
  );
endmodule
`default_nettype wire

// File: rtl/core/etts_front.sv
// Front end: accepts requests, picks the key and holds a two-entry command queue.
// Depends on etts_pkg.
`default_nettype none
module etts_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_key_by_begin,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [1:0]             in_req_type,
  input  wire  [5:0]             in_sat_index,
  input  wire  [31:0]            in_rec_begin,
  input  wire  [31:0]            in_rec_end,
  input  wire  [31:0]            in_rec_toe,
  input  wire  [31:0]            in_query_time,
  output logic                   cmd_valid,
  output etts_pkg::cmd_t         cmd,
  input  wire                    cmd_take
);
  etts_pkg::cmd_t q_r [2];
  etts_pkg::cmd_t q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  etts_pkg::cmd_t c;
  logic acc;

  // Classify the incoming request
  always_comb begin
    c.req = etts_pkg::req_t'(in_req_type);
    c.sat = in_sat_index;
    c.sat_ok = ({2'b0, in_sat_index} < 8'(etts_pkg::NumSats));
    c.rbegin = in_rec_begin;
    c.rend = in_rec_end;
    c.rtoe = in_rec_toe;
    if (c.req == etts_pkg::REQ_INSERT) begin
      c.key = cfg_key_by_begin ? in_rec_begin : in_rec_toe;
    end else begin
      c.key = in_query_time;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign acc = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[0];

  // Advance the queue
  always_comb begin
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    if (cmd_take && cmd_valid) begin
      q_nxt[0] = q_r[1];
      cnt_nxt = cnt_nxt - 2'd1;
    end
    if (acc) begin
      q_nxt[cnt_nxt[0]] = c;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !cmd_valid) else $error("empty queue shows valid");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> in_stall) else $error("full queue not stalled");
endmodule
`default_nettype wire

// File: rtl/core/etts_back.sv
// Back end: scans one satellite table in memory, then inserts, replaces or looks up.
// Depends on etts_pkg.
`default_nettype none
module etts_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cmd_valid,
  input  wire etts_pkg::cmd_t    cmd,
  output logic                   cmd_take,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [2:0]             out_status,
  output logic                   out_found,
  output logic [31:0]            out_begin,
  output logic [31:0]            out_end,
  output logic [31:0]            out_toe
);
  etts_pkg::bst_t st_r, st_nxt;
  etts_pkg::cmd_t c_r, c_nxt;
  etts_pkg::cnt_t cnt_mem [etts_pkg::NumSats];
  logic [etts_pkg::NumSats-1:0] cnt_ok_r;
  etts_pkg::cnt_t cnt_rd_r;
  logic          cnt_okrd_r;
  logic          cnt_we;
  etts_pkg::cnt_t n_r, n_nxt, i_r, i_nxt, p_r, p_nxt;
  logic          pfound_r, pfound_nxt;
  etts_pkg::ent_t mem [etts_pkg::Depth];
  etts_pkg::ent_t rd_r;
  etts_pkg::addr_t raddr;
  logic          we;
  etts_pkg::addr_t waddr;
  etts_pkg::ent_t wdata;
  etts_pkg::ent_t a_r, a_nxt, b_r, b_nxt; // entry at p and at p-1
  logic          rd_pend_r, rd_pend_nxt;
  logic [2:0]    os_r, os_nxt;
  logic          of_r, of_nxt;
  logic [95:0]   orec_r, orec_nxt;
  logic          ov_r, ov_nxt;
  etts_pkg::cnt_t cur_cnt;

  // Counts never written since reset read as zero
  assign cur_cnt = cnt_okrd_r ? cnt_rd_r : '0;
  assign cnt_we = rst_n && (st_r == etts_pkg::S_SHIFT) && (i_r == p_r);

  function automatic etts_pkg::addr_t adr(input logic [etts_pkg::SatW-1:0] s,
                                          input etts_pkg::cnt_t p);
    adr = {s, p[etts_pkg::PosW-1:0]};
  endfunction

  function automatic logic vld(input logic [95:0] r, input logic [31:0] t);
    vld = (r[95:64] <= t) && (t <= r[63:32]);
  endfunction

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // Count memory: read the count of the next command's satellite
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[c_r.sat] <= n_r + etts_pkg::cnt_t'(1);
    end
    cnt_rd_r <= cnt_mem[c_nxt.sat];
    cnt_okrd_r <= cnt_ok_r[c_nxt.sat];
  end

  logic [32:0] to_next, from_last;
  logic        p_eq_n, pick_prev;
  assign p_eq_n = (p_r == n_r);
  assign to_next = {1'b0, a_r.rec[31:0]} - {1'b0, c_r.key};
  assign from_last = {1'b0, c_r.key} - {1'b0, b_r.rec[31:0]};

  // Sequencer: scan finds first key >= target, then act
  always_comb begin
    st_nxt = st_r;
    c_nxt = c_r;
    n_nxt = n_r;
    i_nxt = i_r;
    p_nxt = p_r;
    pfound_nxt = pfound_r;
    a_nxt = a_r;
    b_nxt = b_r;
    rd_pend_nxt = 1'b0;
    os_nxt = os_r;
    of_nxt = of_r;
    orec_nxt = orec_r;
    ov_nxt = ov_r;
    cmd_take = 1'b0;
    raddr = adr(c_r.sat, i_r);
    we = 1'b0;
    waddr = adr(c_r.sat, p_r);
    wdata = '{rec: {c_r.rbegin, c_r.rend, c_r.rtoe}, key: c_r.key};
    pick_prev = 1'b0;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      etts_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          c_nxt = cmd;
          i_nxt = '0;
          pfound_nxt = 1'b0;
          st_nxt = etts_pkg::S_SCAN;
        end
      end
      etts_pkg::S_SCAN: begin
        // first cycle latches count; reads one entry per cycle
        if (!rd_pend_r && i_r == '0 && !pfound_r) begin
          n_nxt = (cur_cnt > etts_pkg::cnt_t'(etts_pkg::EntriesPerSat)) ?
                  etts_pkg::cnt_t'(etts_pkg::EntriesPerSat) : cur_cnt;
        end
        if (rd_pend_r && rd_r.key >= c_r.key && !pfound_r) begin
          pfound_nxt = 1'b1;
          p_nxt = i_r - etts_pkg::cnt_t'(1);
        end
        if (!c_r.sat_ok || (pfound_nxt) ||
            (!rd_pend_r && i_r == '0 && !pfound_r ? 1'b0 : (i_r >= n_nxt))) begin
          if (!pfound_nxt) begin
            p_nxt = n_nxt;
          end
          st_nxt = etts_pkg::S_RDA;
        end else begin
          raddr = adr(c_r.sat, i_r);
          i_nxt = i_r + etts_pkg::cnt_t'(1);
          rd_pend_nxt = 1'b1;
        end
      end
      etts_pkg::S_RDA: begin
        raddr = adr(c_r.sat, p_r);
        st_nxt = etts_pkg::S_RDB;
      end
      etts_pkg::S_RDB: begin
        a_nxt = rd_r;
        raddr = adr(c_r.sat, p_r - etts_pkg::cnt_t'(1));
        rd_pend_nxt = 1'b1;
        st_nxt = etts_pkg::S_DONE;
      end
      etts_pkg::S_DONE: begin
        b_nxt = rd_r;
        if (!rd_pend_r) begin
          // decide with a_r (entry p) and b_r (entry p-1)
          b_nxt = b_r;
          if (!ov_nxt) begin
            st_nxt = etts_pkg::S_IDLE;
            os_nxt = etts_pkg::ST_LOOKUP;
            of_nxt = 1'b0;
            orec_nxt = '0;
            ov_nxt = 1'b1;
            if (c_r.req == etts_pkg::REQ_INSERT) begin
              if (!c_r.sat_ok) begin
                os_nxt = etts_pkg::ST_FULL;
              end else if (!p_eq_n && a_r.key == c_r.key) begin
                os_nxt = (a_r.rec[31:0] == c_r.rtoe) ? etts_pkg::ST_DUP
                                                     : etts_pkg::ST_CONFLICT;
              end else if (!p_eq_n && a_r.rec[31:0] == c_r.rtoe) begin
                we = 1'b1;
                os_nxt = etts_pkg::ST_REPLACED;
              end else if (n_r != '0 && p_eq_n && b_r.rec[31:0] == c_r.rtoe) begin
                os_nxt = etts_pkg::ST_MATCHLAST;
              end else if (p_r != '0 && !p_eq_n && b_r.rec[31:0] == c_r.rtoe) begin
                os_nxt = etts_pkg::ST_LATE;
              end else if (n_r >= etts_pkg::cnt_t'(etts_pkg::EntriesPerSat)) begin
                os_nxt = etts_pkg::ST_FULL;
              end else begin
                ov_nxt = 1'b0;
                i_nxt = n_r;
                st_nxt = etts_pkg::S_SHIFT;
              end
            end else if (c_r.sat_ok && n_r != '0 &&
                         (c_r.req == etts_pkg::REQ_USER ||
                          c_r.req == etts_pkg::REQ_NEAR)) begin
              if (c_r.req == etts_pkg::REQ_USER) begin
                if (p_eq_n) begin
                  of_nxt = vld(b_r.rec, c_r.key); orec_nxt = b_r.rec;
                end else if (vld(a_r.rec, c_r.key)) begin
                  of_nxt = 1'b1; orec_nxt = a_r.rec;
                end else if (p_r != '0) begin
                  of_nxt = vld(b_r.rec, c_r.key); orec_nxt = b_r.rec;
                end
              end else begin
                if (!p_eq_n && a_r.key == c_r.key) begin
                  of_nxt = 1'b1; orec_nxt = a_r.rec;
                end else if (p_r == '0) begin
                  of_nxt = vld(a_r.rec, c_r.key); orec_nxt = a_r.rec;
                end else if (p_eq_n) begin
                  of_nxt = vld(b_r.rec, c_r.key); orec_nxt = b_r.rec;
                end else begin
                  // distances are signed: the query may lie past either Toe
                  pick_prev = ($signed(to_next) > $signed(from_last));
                  if (vld(pick_prev ? b_r.rec : a_r.rec, c_r.key)) begin
                    of_nxt = 1'b1; orec_nxt = pick_prev ? b_r.rec : a_r.rec;
                  end else if (vld(pick_prev ? a_r.rec : b_r.rec, c_r.key)) begin
                    of_nxt = 1'b1; orec_nxt = pick_prev ? a_r.rec : b_r.rec;
                  end
                end
              end
              if (!of_nxt) begin
                orec_nxt = '0;
              end
            end
          end else begin
            st_nxt = etts_pkg::S_DONE;
          end
        end
      end
      etts_pkg::S_SHIFT: begin
        // move entry i-1 to i with a read and then a write, then write the new record
        if (i_r == p_r) begin
          we = 1'b1;
          waddr = adr(c_r.sat, p_r);
          st_nxt = etts_pkg::S_IDLE;
          os_nxt = etts_pkg::ST_ADDED;
          of_nxt = 1'b0;
          orec_nxt = '0;
          ov_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          raddr = adr(c_r.sat, i_r - etts_pkg::cnt_t'(1));
          rd_pend_nxt = 1'b1;
        end else begin
          we = 1'b1;
          waddr = adr(c_r.sat, i_r);
          wdata = rd_r;
          i_nxt = i_r - etts_pkg::cnt_t'(1);
        end
      end
      default: st_nxt = etts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    n_r <= n_nxt;
    i_r <= i_nxt;
    p_r <= p_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    orec_r <= orec_nxt;
    os_r <= os_nxt;
    of_r <= of_nxt;
    if (!rst_n) begin
      st_r <= etts_pkg::S_IDLE;
      ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
      pfound_r <= 1'b0;
      cnt_ok_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
      pfound_r <= pfound_nxt;
      if (cnt_we) begin
        cnt_ok_r[c_r.sat] <= 1'b1;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_found = of_r;
  assign out_begin = orec_r[95:64];
  assign out_end = orec_r[63:32];
  assign out_toe = orec_r[31:0];

  a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == etts_pkg::ST_LOOKUP))
    else $error("found on insert");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("result lost under stall");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> (st_r == etts_pkg::S_IDLE)) else $error("command taken while busy");
endmodule
`default_nettype wire
